FILE: rtl/csvt_pkg.sv
// csvt_pkg: shared types and constants for the csv field tokenizer
// used by csvt_cfg, csvt_core and csv_field_tokenizer_unit; no dependencies
package csvt_pkg;

    // field limit per record; the counter saturates here
    localparam int MAX_FIELDS = 11;
    localparam int FIELD_CNT_W = $clog2(MAX_FIELDS + 1);
    localparam int FIELD_NUM_W = 4;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] NUL_BYTE     = 8'h00;

    localparam logic [7:0] DELIMITER_RESET  = 8'h2C;
    localparam logic [7:0] QUOTE_BYTE_RESET = 8'h22;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register indexes, taken from paddr[2]
    localparam logic REG_DELIMITER  = 1'b0;
    localparam logic REG_QUOTE_BYTE = 1'b1;

    typedef enum logic [1:0] {
        KIND_DATA       = 2'd0,
        KIND_FIELD_END  = 2'd1,
        KIND_RECORD_END = 2'd2
    } item_kind_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_req_t;

    typedef struct packed {
        item_kind_t             item_kind;
        logic [7:0]             data_byte;
        logic [FIELD_NUM_W-1:0] field_number;
        logic                   too_many_fields;
    } token_req_t;

    typedef struct packed {
        logic [7:0] delimiter;
        logic [7:0] quote_byte;
    } csvt_cfg_t;

endpackage

FILE: rtl/csvt_cfg.sv
// csvt_cfg: apb register block holding the delimiter and quote byte
// depends on csvt_pkg
module csvt_cfg
    import csvt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output csvt_cfg_t             cfg
);

    logic [7:0] delimiter_reg;
    logic [7:0] quote_byte_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg  <= DELIMITER_RESET;
            quote_byte_reg <= QUOTE_BYTE_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_DELIMITER:  delimiter_reg  <= pwdata[7:0];
                REG_QUOTE_BYTE: quote_byte_reg <= pwdata[7:0];
                default:        delimiter_reg  <= delimiter_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_DELIMITER:  prdata = {{(APB_DATA_W-8){1'b0}}, delimiter_reg};
            REG_QUOTE_BYTE: prdata = {{(APB_DATA_W-8){1'b0}}, quote_byte_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.delimiter  = delimiter_reg;
    assign cfg.quote_byte = quote_byte_reg;

endmodule

FILE: rtl/csvt_core.sv
// csvt_core: quote and field state, token decode and the result register
// depends on csvt_pkg
module csvt_core
    import csvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  csvt_cfg_t  cfg,
    input  logic       text_valid,
    output logic       text_ready,
    input  text_req_t  text,
    output logic       token_valid,
    input  logic       token_ready,
    output token_req_t token
);

    logic                   inside_quotes_reg, inside_quotes_next;
    logic                   quote_waiting_reg, quote_waiting_next;
    logic                   record_open_reg, record_open_next;
    logic [FIELD_CNT_W-1:0] field_cnt_reg, field_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    token_req_t             out_reg, out_next;

    logic                   accept;
    logic                   emit;
    item_kind_t             kind;
    logic [7:0]             emit_byte;
    logic                   quoted_eff;
    logic [7:0]             b;
    logic                   is_rec_end;
    logic                   is_delim;
    logic [FIELD_CNT_W-1:0] shown;

    // result register frees up in the same cycle it is taken
    assign text_ready = !out_valid_reg || token_ready;
    assign accept     = text_valid && text_ready;
    assign b          = text.text_byte;

    // quote decision lags one byte: a pending lone quote flips quoting first
    assign quoted_eff = (quote_waiting_reg && (b != cfg.quote_byte))
                        ? !inside_quotes_reg : inside_quotes_reg;
    assign is_rec_end = !quoted_eff && ((b == NEWLINE_BYTE) || (b == NUL_BYTE));
    assign is_delim   = !quoted_eff && (b == cfg.delimiter);

    always_comb
    begin
        inside_quotes_next = inside_quotes_reg;
        quote_waiting_next = quote_waiting_reg;
        record_open_next   = record_open_reg;
        field_cnt_next     = field_cnt_reg;
        emit               = 1'b0;
        kind               = KIND_DATA;
        emit_byte          = 8'h00;

        priority if (text.end_of_text)
        begin
            emit               = record_open_reg;
            kind               = KIND_RECORD_END;
            inside_quotes_next = 1'b0;
            quote_waiting_next = 1'b0;
            record_open_next   = 1'b0;
            field_cnt_next     = '0;
        end
        else if (quote_waiting_reg && (b == cfg.quote_byte))
        begin
            // doubled quote is one literal quote
            quote_waiting_next = 1'b0;
            record_open_next   = 1'b1;
            emit               = 1'b1;
            emit_byte          = b;
        end
        else if (!quote_waiting_reg && (b == cfg.quote_byte))
        begin
            quote_waiting_next = 1'b1;
            record_open_next   = 1'b1;
        end
        else
        begin
            quote_waiting_next = 1'b0;
            inside_quotes_next = quoted_eff;
            emit               = 1'b1;
            priority if (is_rec_end)
            begin
                kind             = KIND_RECORD_END;
                field_cnt_next   = '0;
                record_open_next = 1'b0;
            end
            else if (is_delim)
            begin
                kind             = KIND_FIELD_END;
                record_open_next = 1'b1;
                if (field_cnt_reg < FIELD_CNT_W'(MAX_FIELDS))
                begin
                    field_cnt_next = field_cnt_reg + FIELD_CNT_W'(1);
                end
            end
            else
            begin
                record_open_next = 1'b1;
                emit_byte        = b;
            end
        end
    end

    assign shown = (field_cnt_reg > FIELD_CNT_W'(MAX_FIELDS - 1))
                   ? FIELD_CNT_W'(MAX_FIELDS - 1) : field_cnt_reg;

    always_comb
    begin
        out_next.item_kind       = kind;
        out_next.data_byte       = emit_byte;
        out_next.field_number    = FIELD_NUM_W'(shown);
        out_next.too_many_fields = (field_cnt_reg >= FIELD_CNT_W'(MAX_FIELDS));

        out_valid_next = out_valid_reg && !token_ready;
        if (accept)
        begin
            out_valid_next = emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_quotes_reg <= 1'b0;
            quote_waiting_reg <= 1'b0;
            record_open_reg   <= 1'b0;
            field_cnt_reg     <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                inside_quotes_reg <= inside_quotes_next;
                quote_waiting_reg <= quote_waiting_next;
                record_open_reg   <= record_open_next;
                field_cnt_reg     <= field_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            out_reg <= out_next;
        end
    end

    assign token_valid = out_valid_reg;
    assign token       = out_reg;

endmodule

FILE: rtl/csv_field_tokenizer_unit.sv
// csv_field_tokenizer_unit: top level of the csv field tokenizer
// depends on csvt_pkg, csvt_cfg and csvt_core
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------
//  text     | in        | text_valid / text_ready   | text_req_t
//  token    | out       | token_valid / token_ready | token_req_t
//  apb      | in        | psel, penable, pready     | paddr, pwdata, prdata
//
// one text request per clock unless stalled; its token, if any, comes in
// the next cycle from a result register; a new request is taken while
// that register drains (text_ready = !token_valid || token_ready)
// a stall on the token side holds the result and blocks new requests
// reset returns quoting, pending quote, record state and the field counter
// to zero and the registers to comma and double quote
module csv_field_tokenizer_unit
    import csvt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  text_valid,
    output logic                  text_ready,
    input  text_req_t             text,
    output logic                  token_valid,
    input  logic                  token_ready,
    output token_req_t            token
);

    csvt_cfg_t cfg;

    csvt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csvt_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text        (text),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token       (token)
    );

endmodule
